// ===== hw/rtl/ppba_pkg.sv =====
package ppba_pkg;

    // default geometry
    localparam int NUM_PAGES_DEF     = 65536;
    localparam int MAP_WORD_BITS_DEF = 64;

    // payload field widths
    localparam int REQ_TYPE_W    = 2;
    localparam int START_PAGE_W  = 16;
    localparam int RUN_LENGTH_W  = 17;
    localparam int RESULT_PAGE_W = 16;
    localparam int STATUS_W      = 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_ALLOC_AT = 2'd1,
        REQ_FREE     = 2'd2
    } t_req_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOROOM = 2'd1,
        ST_BAD    = 2'd2
    } t_status;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [START_PAGE_W-1:0] start_page;
        logic [RUN_LENGTH_W-1:0] run_length;
    } t_req;

    typedef struct packed {
        logic [RESULT_PAGE_W-1:0] result_page;
        logic [STATUS_W-1:0]      status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PLACE,
        S_MARK,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic place;
        logic mark;
        logic clear;
        logic emit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic bad;
        logic alloc;
        logic found;
        logic miss;
        logic mark_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/ppba_chan_if.sv =====
interface ppba_req_if;
    import ppba_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppba_rsp_if;
    import ppba_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ppba_ram.sv =====
module ppba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ppba_ctrl.sv =====
module ppba_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  ppba_pkg::t_dp_stat   i_stat,
    output ppba_pkg::t_ctrl_cmd  o_cmd
);
    import ppba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.bad)        n_state = S_FINISH;
                else if (i_stat.alloc) n_state = S_SCAN;
                else                   n_state = S_MARK;
            end
            S_SCAN: begin
                if (i_stat.found)     n_state = S_PLACE;
                else if (i_stat.miss) n_state = S_FINISH;
            end
            S_PLACE: begin
                n_state = S_MARK;
            end
            S_MARK: begin
                if (i_stat.mark_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
            end
            S_FINISH: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

// ===== hw/rtl/ppba_dp.sv =====
module ppba_dp #(
    parameter int NUM_PAGES     = ppba_pkg::NUM_PAGES_DEF,
    parameter int MAP_WORD_BITS = ppba_pkg::MAP_WORD_BITS_DEF,
    localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ppba_pkg::t_ctrl_cmd      i_cmd,
    output ppba_pkg::t_dp_stat       o_stat,
    input  ppba_pkg::t_req           i_req_payload,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output ppba_pkg::t_rsp           o_rsp_payload,
    output logic                     o_ram_we,
    output logic [AW-1:0]            o_ram_waddr,
    output logic [MAP_WORD_BITS-1:0] o_ram_wdata,
    output logic                     o_ram_re,
    output logic [AW-1:0]            o_ram_raddr,
    input  logic [MAP_WORD_BITS-1:0] i_ram_rdata
);
    import ppba_pkg::*;

    localparam int MW = MAP_WORD_BITS;
    localparam int BW = $clog2(MW);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int EW = ((CW > RUN_LENGTH_W) ? CW : RUN_LENGTH_W) + 1;
    localparam int LAST_REM = NUM_PAGES - (MAP_WORDS - 1) * MW;
    localparam logic [MW-1:0] LAST_MASK = {MW{1'b1}} >> (MW - LAST_REM);

    // window of k free bits ending at each position, built by doubling
    function automatic logic [MW-1:0] win_free(input logic [MW-1:0] free_v,
                                               input logic [BW:0]   k);
        logic [MW-1:0] pw;
        logic [MW-1:0] acc;
        logic          started;
        pw      = free_v;
        acc     = '0;
        started = 1'b0;
        for (int j = 0; j <= BW; j++) begin
            if (k[j]) begin
                acc     = started ? (pw & (acc << (1 << j))) : pw;
                started = 1'b1;
            end
            pw = pw & (pw << (1 << j));
        end
        return acc;
    endfunction

    // control registers
    logic [AW-1:0] r_raddr;
    logic          r_dvalid;
    logic          r_found;
    logic          r_miss;
    logic          r_issue_end;
    logic          r_mark_done;
    logic          r_out_valid;

    // payload registers
    logic [AW-1:0]            r_daddr;
    logic [CW-1:0]            r_carry;
    logic [AW-1:0]            r_hit_word;
    logic [BW-1:0]            r_hit_idx;
    logic [REQ_TYPE_W-1:0]    r_kind;
    logic                     r_bad;
    logic [CW-1:0]            r_len;
    logic [PW-1:0]            r_first;
    logic [PW-1:0]            r_last;
    t_status                  r_status;
    logic [RESULT_PAGE_W-1:0] r_out_page;
    logic [STATUS_W-1:0]      r_out_status;

    // request check
    logic [EW-1:0] w_start_e;
    logic [EW-1:0] w_len_e;
    logic [EW-1:0] w_last_e;
    logic          w_kind_ok;
    logic          w_bad;
    logic [PW-1:0] w_start_pg;

    assign w_start_e  = EW'(i_req_payload.start_page);
    assign w_len_e    = EW'(i_req_payload.run_length);
    assign w_last_e   = w_start_e + w_len_e - EW'(1);
    assign w_start_pg = PW'(i_req_payload.start_page);
    assign w_kind_ok  = (i_req_payload.req_type == REQ_ALLOC) ||
                        (i_req_payload.req_type == REQ_ALLOC_AT) ||
                        (i_req_payload.req_type == REQ_FREE);
    assign w_bad = (i_req_payload.run_length == '0) ||
                   (w_len_e > EW'(NUM_PAGES)) ||
                   !w_kind_ok ||
                   ((i_req_payload.req_type != REQ_ALLOC) &&
                    (w_start_e + w_len_e > EW'(NUM_PAGES)));

    // scan evaluation of the word coming out of the map
    logic          w_eval;
    logic          w_last_word;
    logic [MW-1:0] w_free;
    logic [CW-1:0] w_need;
    logic [MW-1:0] w_hit;
    logic [BW-1:0] w_hit_idx;
    logic [CW-1:0] w_top_run;
    logic [CW-1:0] w_carry_nx;
    logic          w_stop;
    logic          w_issue_scan;
    logic          w_issue_mark;

    assign w_eval      = i_cmd.scan && r_dvalid;
    assign w_last_word = (r_daddr == AW'(MAP_WORDS - 1));
    assign w_free      = ~i_ram_rdata & (w_last_word ? LAST_MASK : {MW{1'b1}});
    assign w_need      = r_len - r_carry;

    always_comb begin
        logic [MW-1:0] pf;
        logic [MW-1:0] win;
        for (int i = 0; i < MW; i++) begin
            pf[i] = ((~w_free & ({MW{1'b1}} >> (MW - 1 - i))) == '0);
        end
        win   = win_free(w_free, r_len[BW:0]);
        w_hit = '0;
        for (int i = 0; i < MW; i++) begin
            w_hit[i] = pf[i] && (w_need <= CW'(i + 1));
        end
        if (r_len <= CW'(MW)) begin
            w_hit = w_hit | win;
        end
    end

    // lowest hit and free run at the top of the word
    always_comb begin
        w_hit_idx = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (w_hit[i]) w_hit_idx = BW'(i);
        end
        w_top_run = CW'(MW);
        for (int i = 0; i < MW; i++) begin
            if (!w_free[i]) w_top_run = CW'(MW - 1 - i);
        end
        w_carry_nx = (&w_free) ? (r_carry + CW'(MW)) : w_top_run;
    end

    assign w_stop       = w_eval && ((|w_hit) || w_last_word);
    assign w_issue_scan = i_cmd.scan && !r_found && !r_miss && !w_stop;
    assign w_issue_mark = i_cmd.mark && !r_issue_end;

    // placement of the found run
    logic [CW-1:0] w_end_c;
    logic [PW-1:0] w_place_first;

    assign w_end_c       = CW'({r_hit_word, r_hit_idx});
    assign w_place_first = PW'(w_end_c + CW'(1) - r_len);

    // mark / release of a run, one word per cycle
    logic [AW-1:0] w_ws;
    logic [AW-1:0] w_we;
    logic [MW-1:0] w_mask;
    logic [MW-1:0] w_marked;
    logic          w_mark_wr;

    assign w_ws      = AW'(r_first >> BW);
    assign w_we      = AW'(r_last >> BW);
    assign w_mark_wr = i_cmd.mark && r_dvalid;

    always_comb begin
        for (int i = 0; i < MW; i++) begin
            w_mask[i] = ((r_daddr != w_ws) || (BW'(i) >= r_first[BW-1:0])) &&
                        ((r_daddr != w_we) || (BW'(i) <= r_last[BW-1:0]));
        end
        w_marked = (r_kind == REQ_FREE) ? (i_ram_rdata & ~w_mask) : (i_ram_rdata | w_mask);
    end

    assign o_ram_re    = w_issue_scan || w_issue_mark;
    assign o_ram_raddr = r_raddr;
    assign o_ram_we    = i_cmd.clear || w_mark_wr;
    assign o_ram_waddr = i_cmd.clear ? r_raddr : r_daddr;
    assign o_ram_wdata = i_cmd.clear ? '0 : w_marked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raddr     <= '0;
            r_dvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_miss      <= 1'b0;
            r_issue_end <= 1'b0;
            r_mark_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dvalid <= w_issue_scan || w_issue_mark;

            if (i_cmd.load) begin
                r_raddr <= (i_req_payload.req_type == REQ_ALLOC) ? '0
                                                                 : AW'(w_start_pg >> BW);
            end else if (i_cmd.place) begin
                r_raddr <= AW'(w_place_first >> BW);
            end else if (i_cmd.clear || w_issue_scan || w_issue_mark) begin
                r_raddr <= r_raddr + AW'(1);
            end

            if (i_cmd.load) begin
                r_found     <= 1'b0;
                r_miss      <= 1'b0;
                r_issue_end <= 1'b0;
                r_mark_done <= 1'b0;
            end else begin
                if (w_eval && (|w_hit)) r_found <= 1'b1;
                if (w_eval && !(|w_hit) && w_last_word) r_miss <= 1'b1;
                if (w_issue_mark && (r_raddr == w_we)) r_issue_end <= 1'b1;
                if (w_mark_wr && (r_daddr == w_we)) r_mark_done <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= r_raddr;

        if (i_cmd.load) begin
            r_kind   <= i_req_payload.req_type;
            r_bad    <= w_bad;
            r_len    <= CW'(i_req_payload.run_length);
            r_first  <= w_start_pg;
            r_last   <= PW'(w_last_e);
            r_carry  <= '0;
            r_status <= w_bad ? ST_BAD : ST_OK;
        end else if (i_cmd.place) begin
            r_first <= w_place_first;
            r_last  <= PW'({r_hit_word, r_hit_idx});
        end else if (w_eval) begin
            if (|w_hit) begin
                r_hit_word <= r_daddr;
                r_hit_idx  <= w_hit_idx;
            end else if (w_last_word) begin
                r_status <= ST_NOROOM;
            end else begin
                r_carry <= w_carry_nx;
            end
        end

        if (i_cmd.emit) begin
            r_out_page   <= (r_status == ST_OK) ? RESULT_PAGE_W'(r_first) : '0;
            r_out_status <= r_status;
        end
    end

    assign o_stat.clear_last = (r_raddr == AW'(MAP_WORDS - 1));
    assign o_stat.bad        = r_bad;
    assign o_stat.alloc      = (r_kind == REQ_ALLOC);
    assign o_stat.found      = r_found;
    assign o_stat.miss       = r_miss;
    assign o_stat.mark_done  = r_mark_done;
    assign o_stat.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid               = r_out_valid;
    assign o_rsp_payload.result_page = r_out_page;
    assign o_rsp_payload.status      = r_out_status;
endmodule

// ===== hw/rtl/physical_page_bitmap_allocator_top.sv =====
// from request transfer to result valid: bad request, dispatch then finish; allocate-at / free,
// marks W map words; allocate scans S words from word 0, places, marks; no room scans all words
// throughput: one request at a time, the map stepped one word a cycle; the next request
// transfer is taken in the idle state, entered as the result is loaded into the output register
// reset: synchronous active low; then a clearing pass zeroes one map word a cycle and no
// request is taken until it is done (1024 map words by default)
module physical_page_bitmap_allocator_top #(
    parameter int NUM_PAGES     = ppba_pkg::NUM_PAGES_DEF,
    parameter int MAP_WORD_BITS = ppba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppba_req_if.sink   i_req,
    ppba_rsp_if.source o_rsp
);
    import ppba_pkg::*;

    // map geometry: MAP_WORD_BITS must be a power of two, which the block does not check; one bit per page
    localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    logic                     w_ram_we;
    logic [AW-1:0]            w_ram_waddr;
    logic [MAP_WORD_BITS-1:0] w_ram_wdata;
    logic                     w_ram_re;
    logic [AW-1:0]            w_ram_raddr;
    logic [MAP_WORD_BITS-1:0] w_ram_rdata;

    // sequencer: clearing pass, dispatch, first-fit scan, placement, mark/release,
    // and hand-off of the result into the output register
    ppba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: request check, word-wide run search with a carried free count
    // across words, read-modify-write masks, and the output register; a new
    // request transfer can be taken while a result still waits in that register
    ppba_dp #(
        .NUM_PAGES     (NUM_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_payload (i_req.payload),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_payload (o_rsp.payload),
        .o_ram_we      (w_ram_we),
        .o_ram_waddr   (w_ram_waddr),
        .o_ram_wdata   (w_ram_wdata),
        .o_ram_re      (w_ram_re),
        .o_ram_raddr   (w_ram_raddr),
        .i_ram_rdata   (w_ram_rdata)
    );

    // occupancy bitmap: one write and one registered read port, so a run is
    // updated at one word per cycle with the read of the next word overlapped
    ppba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ppba_pkg::*;

    localparam int NUM_PAGES   = NUM_PAGES_DEF;
    localparam int RANDOM_REQS = 540;
    // longest quiet stretch: clearing pass, a full scan plus a full mark, stalls on top
    localparam int STALL_LIMIT = 20000;
    // drain time after the last reply, worst allocate latency with margin
    localparam int DRAIN_CYCLES = 2200;
    // request code the block does not know
    localparam logic [REQ_TYPE_W-1:0] REQ_UNDEF = 2'd3;

    typedef struct {
        logic [REQ_TYPE_W-1:0] kind;
        int unsigned           first;
        int unsigned           len;
        bit                    typed;
        t_rsp                  reply;
    } t_stim_row;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } t_page_run;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppba_req_if req_ch ();
    ppba_rsp_if rsp_ch ();

    physical_page_bitmap_allocator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // own copy of the occupancy map, one bit per page, 1 = used
    bit page_busy [NUM_PAGES];
    // replies owed by the block, oldest first
    t_rsp outcome_q [$];
    // runs handed out and not yet released, used to build well-formed frees
    t_page_run held_runs [$];
    t_stim_row dir_rows [$];

    int  n_err;
    int  n_reqs;
    int  n_ok;
    int  n_noroom;
    int  n_bad;
    bit  req_quiet;
    bit  rsp_quiet;
    t_rsp last_outcome;

    // mark or release a run in the local map
    function automatic void paint_run(input int unsigned first, input int unsigned len,
                                      input bit used);
        int unsigned p;
        for (p = first; p < first + len; p++) begin
            page_busy[p] = used;
        end
    endfunction

    // what the block must answer for one request, updating the local map on the way
    function automatic t_rsp alloc_outcome(input t_req r);
        int unsigned kind;
        int unsigned first;
        int unsigned len;
        int unsigned run;
        int unsigned p;
        t_rsp        o;
        kind  = 32'(r.req_type);
        first = 32'(r.start_page);
        len   = 32'(r.run_length);
        o.result_page = '0;
        o.status      = ST_BAD;
        if (len != 0 && len <= NUM_PAGES) begin
            if (kind == REQ_ALLOC) begin
                // first fit from page 0
                o.status = ST_NOROOM;
                run = 0;
                for (p = 0; p < NUM_PAGES; p++) begin
                    run = page_busy[p] ? 0 : run + 1;
                    if (run == len) begin
                        first = p + 1 - len;
                        paint_run(first, len, 1'b1);
                        o.status      = ST_OK;
                        o.result_page = first[RESULT_PAGE_W-1:0];
                        break;
                    end
                end
            end else if (kind == REQ_ALLOC_AT || kind == REQ_FREE) begin
                // no overlap check, only the end of the map counts
                if (len <= NUM_PAGES - first) begin
                    paint_run(first, len, kind == REQ_ALLOC_AT);
                    o.status      = ST_OK;
                    o.result_page = first[RESULT_PAGE_W-1:0];
                end
            end
        end
        return o;
    endfunction

    function automatic t_req mk_req(input logic [REQ_TYPE_W-1:0] kind,
                                    input int unsigned first, input int unsigned len);
        t_req r;
        r.req_type   = kind;
        r.start_page = first[START_PAGE_W-1:0];
        r.run_length = len[RUN_LENGTH_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input logic [REQ_TYPE_W-1:0] kind,
                                    input int unsigned first, input int unsigned len,
                                    input bit typed, input int unsigned page,
                                    input t_status st);
        t_stim_row row;
        row.kind               = kind;
        row.first              = first;
        row.len                = len;
        row.typed              = typed;
        row.reply.result_page  = page[RESULT_PAGE_W-1:0];
        row.reply.status       = st;
        dir_rows.push_back(row);
    endfunction

    // one request transfer; the owed reply is queued at the accepting edge
    task automatic send_req(input t_req r, input bit typed, input t_rsp typed_reply);
        int gap;
        t_rsp pred;
        if ($urandom_range(0, 29) == 0) req_quiet = ~req_quiet;
        gap = req_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pred = alloc_outcome(r);
        outcome_q.push_back(typed ? typed_reply : pred);
        last_outcome = pred;
        n_reqs++;
    endtask

    // request side: reset, directed table, random traffic, drain, verdict
    initial begin
        t_req                  r;
        t_rsp                  none;
        t_page_run             hr;
        logic [REQ_TYPE_W-1:0] kind;
        int unsigned           first;
        int unsigned           len;
        int unsigned           cap;
        int                    pick;
        int                    sel;

        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        n_err     = 0;
        n_reqs    = 0;
        req_quiet = 1'b0;
        none      = '0;

        // zero length, full map, edges of the map
        add_row(REQ_ALLOC,    0,     0,      1, 0,     ST_BAD);
        add_row(REQ_ALLOC,    0,     65536,  1, 0,     ST_OK);
        add_row(REQ_FREE,     0,     65536,  1, 0,     ST_OK);
        add_row(REQ_ALLOC,    0,     1,      1, 0,     ST_OK);
        add_row(REQ_ALLOC,    0,     1,      1, 1,     ST_OK);
        add_row(REQ_ALLOC_AT, 65535, 1,      1, 65535, ST_OK);
        add_row(REQ_ALLOC_AT, 65535, 2,      1, 0,     ST_BAD);
        add_row(REQ_FREE,     65535, 1,      1, 65535, ST_OK);
        // too long, all-ones length, unknown code, zero length for free and allocate-at
        add_row(REQ_ALLOC,    0,     65537,  1, 0,     ST_BAD);
        add_row(REQ_ALLOC,    65535, 131071, 1, 0,     ST_BAD);
        add_row(REQ_UNDEF,    65535, 5,      1, 0,     ST_BAD);
        add_row(REQ_FREE,     0,     0,      1, 0,     ST_BAD);
        add_row(REQ_ALLOC_AT, 0,     0,      1, 0,     ST_BAD);
        // no room for a whole-map run while two pages are held
        add_row(REQ_ALLOC,    0,     65536,  1, 0,     ST_NOROOM);
        // free twice, second one on free pages
        add_row(REQ_FREE,     1,     1,      1, 1,     ST_OK);
        add_row(REQ_FREE,     1,     1,      1, 1,     ST_OK);
        // allocate-at over a used page
        add_row(REQ_ALLOC_AT, 0,     4,      1, 0,     ST_OK);
        add_row(REQ_ALLOC,    0,     3,      0, 0,     ST_OK);
        // fill everything, then open one hole
        add_row(REQ_ALLOC_AT, 0,     65536,  1, 0,     ST_OK);
        add_row(REQ_ALLOC,    0,     1,      1, 0,     ST_NOROOM);
        add_row(REQ_FREE,     100,   50,     1, 100,   ST_OK);
        add_row(REQ_ALLOC,    0,     60,     0, 0,     ST_OK);
        add_row(REQ_ALLOC,    0,     50,     0, 0,     ST_OK);
        add_row(REQ_FREE,     0,     65536,  1, 0,     ST_OK);
        add_row(REQ_FREE,     32768, 32769,  1, 0,     ST_BAD);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_req(mk_req(dir_rows[i].kind, dir_rows[i].first, dir_rows[i].len),
                     dir_rows[i].typed, dir_rows[i].reply);
        end

        for (int i = 0; i < RANDOM_REQS; i++) begin
            sel = $urandom_range(0, 99);
            if (i % 64 == 63) begin
                // wipe the map now and then so scans stay short
                r = mk_req(REQ_FREE, 0, NUM_PAGES);
                held_runs.delete();
            end else if (i % 64 == 0 && $urandom_range(0, 3) == 0) begin
                // whole-map request right after a wipe
                r = mk_req(REQ_ALLOC, 0, NUM_PAGES);
            end else if (sel < 35) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len = $urandom_range(1, 64);
                else if (pick < 95) len = $urandom_range(65, 1024);
                else len = $urandom_range(1025, 8192);
                r = mk_req(REQ_ALLOC, $urandom_range(0, 65535), len);
            end else if (sel < 60 && held_runs.size() != 0) begin
                // release a run that is held, sometimes only its head
                pick = $urandom_range(0, held_runs.size() - 1);
                hr = held_runs[pick];
                held_runs.delete(pick);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, hr.len) : hr.len;
                r = mk_req(REQ_FREE, hr.first, len);
            end else if (sel < 70) begin
                first = $urandom_range(0, 65535);
                cap = NUM_PAGES - first;
                len = $urandom_range(1, (cap < 64) ? cap : 64);
                r = mk_req(REQ_ALLOC_AT, first, len);
            end else if (sel < 80) begin
                first = $urandom_range(0, 65535);
                cap = NUM_PAGES - first;
                len = $urandom_range(1, (cap < 256) ? cap : 256);
                r = mk_req(REQ_FREE, first, len);
            end else if (sel < 88) begin
                r = mk_req(REQ_ALLOC, 0, $urandom_range(1, 32));
            end else begin
                // malformed requests
                pick  = $urandom_range(0, 3);
                kind  = REQ_TYPE_W'($urandom_range(0, 2));
                first = $urandom_range(0, 65535);
                case (pick)
                    0: begin
                        r = mk_req(REQ_UNDEF, first, $urandom_range(0, 131071));
                    end
                    1: begin
                        r = mk_req(kind, first, 0);
                    end
                    2: begin
                        r = mk_req(kind, first, $urandom_range(65537, 131071));
                    end
                    default: begin
                        len = NUM_PAGES - first + $urandom_range(1, 64);
                        r = mk_req($urandom_range(0, 1) ? REQ_ALLOC_AT : REQ_FREE,
                                   first, len);
                    end
                endcase
            end
            send_req(r, 1'b0, none);
            if (last_outcome.status == ST_OK &&
                (r.req_type == REQ_ALLOC || r.req_type == REQ_ALLOC_AT)) begin
                hr.first = 32'(last_outcome.result_page);
                hr.len   = 32'(r.run_length);
                held_runs.push_back(hr);
            end
        end
        req_ch.valid <= 1'b0;

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d granted, %0d no room, %0d rejected",
                 n_reqs, n_ok, n_noroom, n_bad);
        $display("first fit, allocate-at, free, bad lengths and codes; %0d mismatches",
                 n_err);
        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // reply side: random back-pressure, compare against the oldest owed reply
    initial begin
        int   stall;
        t_rsp got;
        t_rsp want;
        rsp_ch.ready <= 1'b0;
        rsp_quiet = 1'b0;
        n_ok      = 0;
        n_noroom  = 0;
        n_bad     = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) rsp_quiet = ~rsp_quiet;
            stall = rsp_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            got = rsp_ch.payload;
            case (got.status)
                ST_OK:     n_ok++;
                ST_NOROOM: n_noroom++;
                default:   n_bad++;
            endcase
            if (outcome_q.size() == 0) begin
                $display("%0t: reply with none owed, page %0d status %0d",
                         $time, got.result_page, got.status);
                n_err++;
            end else begin
                want = outcome_q.pop_front();
                if (got.result_page !== want.result_page) begin
                    $display("%0t: result_page expected %0d actual %0d",
                             $time, want.result_page, got.result_page);
                    n_err++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    n_err++;
                end
            end
        end
    end

    // watchdog: too many cycles with no transfer on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles, %0d replies still owed",
                 $time, STALL_LIMIT, outcome_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
